### rtl/two_color_run_pair_decoder_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-color run-pair decoder
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef TWO_COLOR_RUN_PAIR_DECODER_DEFINES_SVH
`define TWO_COLOR_RUN_PAIR_DECODER_DEFINES_SVH

// Same-cycle implication.
`define TRCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TRCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/trcd_pkg.sv
// ---------------------------------------------------------------------------
// trcd_pkg
// Constants, codes and controller/datapath interface types of the decoder.
// ---------------------------------------------------------------------------
package trcd_pkg;

  // Header bytes and run bias
  localparam logic [7:0] HDR_ESC   = 8'h1B;
  localparam logic [7:0] HDR_G     = 8'h47;
  localparam logic [7:0] HDR_LARGE = 8'h48;
  localparam logic [7:0] HDR_SMALL = 8'h4D;
  localparam logic [7:0] RUN_BIAS  = 8'h20;

  // Picture geometry
  localparam logic [9:0]  WIDTH_LARGE  = 10'd256;
  localparam logic [9:0]  WIDTH_SMALL  = 10'd128;
  localparam logic [7:0]  HEIGHT_LARGE = 8'd192;
  localparam logic [7:0]  HEIGHT_SMALL = 8'd96;
  localparam logic [12:0] BYTES_LARGE  = 13'd6144;
  localparam logic [12:0] BYTES_SMALL  = 13'd1536;
  localparam logic [9:0]  COL_MAX      = 10'd1023;
  localparam logic [7:0]  ALL_PIXELS   = 8'hFF;

  // Result kinds
  localparam logic KIND_PIXELS     = 1'b0;
  localparam logic KIND_BAD_HEADER = 1'b1;

  // File phase
  typedef enum logic [5:0] {
    P_HDR0  = 6'b000001,
    P_HDR1  = 6'b000010,
    P_HDR2  = 6'b000100,
    P_WHITE = 6'b001000,
    P_BLACK = 6'b010000,
    P_DONE  = 6'b100000
  } phase_t;

  // Sequencer state
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RUN    = 4'b0010,
    S_FINISH = 4'b0100,
    S_ERR    = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic clear;       // restart: drop all picture state
    logic set_size;    // latch picture size
    logic size_large;
    logic load_white;  // start a white run from the input byte
    logic load_black;  // start a black run, update column/row
    logic step;        // pack up to one output byte worth of pixels
    logic finish;      // flush partial byte or send terminator
    logic bad_header;  // send the invalid-header result
  } dp_cmd_t;

  typedef struct packed {
    logic esc_ok;
    logic g_ok;
    logic large_ok;
    logic small_ok;
    logic black_ends;  // this black byte completes the last row
    logic slot_free;   // output register can take a result
    logic run_last;    // the current step consumes the rest of the run
    logic end_pending; // current run ends the picture
  } dp_status_t;

endpackage

### rtl/trcd_datapath.sv
// ---------------------------------------------------------------------------
// trcd_datapath
// Run packing, column/row bookkeeping and the registered result stage.
// ---------------------------------------------------------------------------
module trcd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          file_byte,
  input  trcd_pkg::dp_cmd_t   cmd,
  output trcd_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          pixel_byte,
  output logic                kind,
  output logic                large_picture,
  output logic                final_byte
);
  import trcd_pkg::*;

  logic        size_select;
  logic [7:0]  partial_byte;
  logic [2:0]  pending_bits;
  logic [9:0]  column_count;
  logic [7:0]  row_count;
  logic [12:0] bytes_emitted;
  logic [7:0]  white_run_held;
  logic [7:0]  remaining;
  logic        run_white;
  logic        end_flag;
  logic        any_sent;

  logic [7:0]  run_len;
  logic [10:0] col_sum;
  logic [9:0]  col_sat;
  logic [9:0]  width;
  logic [7:0]  height;
  logic [12:0] limit;
  logic        wrap;
  logic [9:0]  col_next;
  logic [7:0]  row_next;

  logic [3:0]  space;
  logic [3:0]  take;
  logic [3:0]  fill;
  logic [7:0]  mask;
  logic [7:0]  merged;
  logic [7:0]  rem_after;
  logic        full;
  logic        under;
  logic        step_emit;
  logic        step_final;
  logic        flush_emit;
  logic        term_emit;
  logic        slot_free;

  assign width  = size_select ? WIDTH_LARGE  : WIDTH_SMALL;
  assign height = size_select ? HEIGHT_LARGE : HEIGHT_SMALL;
  assign limit  = size_select ? BYTES_LARGE  : BYTES_SMALL;

  // Black run bookkeeping
  assign run_len  = file_byte - RUN_BIAS;
  assign col_sum  = {1'b0, column_count} + {3'b000, white_run_held} + {3'b000, run_len};
  assign col_sat  = (col_sum > {1'b0, COL_MAX}) ? COL_MAX : col_sum[9:0];
  assign wrap     = (col_sat >= width);
  assign col_next = wrap ? (col_sat - width) : col_sat;
  assign row_next = row_count + {7'd0, wrap};

  // One packing step: fill the partial byte as far as the run allows
  assign space     = 4'd8 - {1'b0, pending_bits};
  assign take      = (remaining < {4'd0, space}) ? remaining[3:0] : space;
  assign fill      = {1'b0, pending_bits} + take;
  assign mask      = (ALL_PIXELS >> pending_bits) & ~(ALL_PIXELS >> fill);
  assign merged    = partial_byte | (run_white ? mask : 8'h00);
  assign rem_after = remaining - {4'd0, take};
  assign full      = fill[3];
  assign under     = (bytes_emitted < limit);

  assign step_emit  = cmd.step && full && under;
  assign step_final = end_flag && ((rem_after == 8'd0) || (bytes_emitted + 13'd1 == limit));
  assign flush_emit = cmd.finish && (pending_bits != 3'd0) && under;
  assign term_emit  = cmd.finish && !flush_emit && !any_sent;

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    status             = '0;
    status.esc_ok      = (file_byte == HDR_ESC);
    status.g_ok        = (file_byte == HDR_G);
    status.large_ok    = (file_byte == HDR_LARGE);
    status.small_ok    = (file_byte == HDR_SMALL);
    status.black_ends  = (row_next >= height);
    status.slot_free   = slot_free;
    status.run_last    = (rem_after == 8'd0);
    status.end_pending = end_flag;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      size_select    <= 1'b0;
      partial_byte   <= 8'h00;
      pending_bits   <= 3'd0;
      column_count   <= 10'd0;
      row_count      <= 8'd0;
      bytes_emitted  <= 13'd0;
      white_run_held <= 8'd0;
      remaining      <= 8'd0;
      run_white      <= 1'b0;
      end_flag       <= 1'b0;
      any_sent       <= 1'b0;
    end else begin
      if (cmd.set_size) begin
        size_select <= cmd.size_large;
      end
      if (cmd.load_white) begin
        white_run_held <= run_len;
        remaining      <= run_len;
        run_white      <= 1'b1;
        end_flag       <= 1'b0;
      end
      if (cmd.load_black) begin
        remaining    <= run_len;
        run_white    <= 1'b0;
        column_count <= col_next;
        row_count    <= row_next;
        end_flag     <= (row_next >= height);
        any_sent     <= 1'b0;
      end
      if (cmd.step) begin
        remaining <= rem_after;
        if (full) begin
          partial_byte <= 8'h00;
          pending_bits <= 3'd0;
        end else begin
          partial_byte <= merged;
          pending_bits <= fill[2:0];
        end
      end
      if (cmd.finish) begin
        partial_byte <= 8'h00;
        pending_bits <= 3'd0;
      end
      if (step_emit || flush_emit) begin
        bytes_emitted <= bytes_emitted + 13'd1;
        any_sent      <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_emit || flush_emit || term_emit || cmd.bad_header) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_emit || flush_emit || term_emit || cmd.bad_header) begin
      priority if (step_emit) begin
        pixel_byte    <= merged;
        kind          <= KIND_PIXELS;
        large_picture <= size_select;
        final_byte    <= step_final;
      end else if (flush_emit) begin
        pixel_byte    <= partial_byte;
        kind          <= KIND_PIXELS;
        large_picture <= size_select;
        final_byte    <= 1'b1;
      end else if (term_emit) begin
        pixel_byte    <= 8'h00;
        kind          <= KIND_PIXELS;
        large_picture <= size_select;
        final_byte    <= 1'b1;
      end else begin
        pixel_byte    <= 8'h00;
        kind          <= KIND_BAD_HEADER;
        large_picture <= 1'b0;
        final_byte    <= 1'b1;
      end
    end
  end

endmodule

### rtl/trcd_ctrl.sv
// ---------------------------------------------------------------------------
// trcd_ctrl
// File phase tracking and the run sequencer that drives the datapath.
// ---------------------------------------------------------------------------
module trcd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 new_file,
  input  trcd_pkg::dp_status_t status,
  output trcd_pkg::dp_cmd_t    cmd
);
  import trcd_pkg::*;

  seq_state_t state, state_next;
  phase_t     phase, phase_next, eff_phase;
  logic       accept;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign eff_phase = new_file ? P_HDR0 : phase;

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.clear = new_file;
          unique case (eff_phase)
            P_HDR0: begin
              if (status.esc_ok) begin
                phase_next = P_HDR1;
              end else begin
                phase_next = P_DONE;
                state_next = S_ERR;
              end
            end
            P_HDR1: begin
              if (status.g_ok) begin
                phase_next = P_HDR2;
              end else begin
                phase_next = P_DONE;
                state_next = S_ERR;
              end
            end
            P_HDR2: begin
              if (status.large_ok || status.small_ok) begin
                cmd.set_size   = 1'b1;
                cmd.size_large = status.large_ok;
                phase_next     = P_WHITE;
              end else begin
                phase_next = P_DONE;
                state_next = S_ERR;
              end
            end
            P_WHITE: begin
              cmd.load_white = 1'b1;
              phase_next     = P_BLACK;
              state_next     = S_RUN;
            end
            P_BLACK: begin
              cmd.load_black = 1'b1;
              phase_next     = status.black_ends ? P_DONE : P_WHITE;
              state_next     = S_RUN;
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
      S_RUN: begin
        if (status.slot_free) begin
          cmd.step = 1'b1;
          if (status.run_last) begin
            state_next = status.end_pending ? S_FINISH : S_IDLE;
          end
        end
      end
      S_FINISH: begin
        if (status.slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        if (status.slot_free) begin
          cmd.bad_header = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= P_HDR0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

### rtl/two_color_run_pair_decoder.sv
// ---------------------------------------------------------------------------
// two_color_run_pair_decoder
// Decodes a two-color run-pair picture file into packed 1-bit pixels.
// ---------------------------------------------------------------------------
// Input channel: one file byte per transaction (in_valid, in_stall, file_byte,
// new_file). new_file marks the first header byte and restarts decoding.
// Output channel: one result per transaction (out_valid, out_stall,
// pixel_byte, kind, large_picture, final_byte). Pixels are packed MSB first,
// white as 1; kind flags an invalid header, final_byte the picture's end.
// Header bytes are checked on accept. A run byte is accepted, then packed
// in steps that each fill the current output byte as far as the run
// allows; the run byte that ends the picture then takes a finishing step
// that flushes the partial byte or sends a terminator. The shared packing
// step gives at most one result byte per cycle while out_stall is low; a
// result follows in the cycle after its step. A bad header posts an error.
// Stalls: results sit in a single output register; while out_stall holds a
// result the sequencer waits and in_stall stays high until its run is done.
// Between runs a new byte is accepted even with a result still waiting.
// Reset (rst, synchronous) returns to waiting for the first header byte.
// ---------------------------------------------------------------------------
module two_color_run_pair_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] file_byte,
  input  logic       new_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pixel_byte,
  output logic       kind,
  output logic       large_picture,
  output logic       final_byte
);
  import trcd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: phase of the file and run iteration
  trcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .new_file (new_file),
    .status   (status),
    .cmd      (cmd)
  );

  // Packing, bookkeeping and result register
  trcd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .file_byte     (file_byte),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_byte    (pixel_byte),
    .kind          (kind),
    .large_picture (large_picture),
    .final_byte    (final_byte)
  );

endmodule

### rtl/trcd_checker.sv
// ---------------------------------------------------------------------------
// trcd_checker
// Port-level checks of the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "two_color_run_pair_decoder_defines.svh"

module trcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] file_byte,
  input logic       new_file,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] pixel_byte,
  input logic       kind,
  input logic       large_picture,
  input logic       final_byte
);
  import trcd_pkg::*;

  // Hold a stalled result
  `TRCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_byte) && $stable(final_byte), "stalled result changed")

  // Error result carries no pixels and closes the picture
  `TRCD_ASSERT_NOW(a_err_shape, out_valid && (kind == KIND_BAD_HEADER), final_byte && (pixel_byte == 8'h00) && !large_picture, "malformed error result")

  // Bad first header byte keeps the block busy posting the error
  `TRCD_ASSERT_NEXT(a_bad_start_busy, in_valid && !in_stall && new_file && (file_byte != HDR_ESC), in_stall, "bad header accepted without error cycle")

endmodule

bind two_color_run_pair_decoder trcd_checker u_trcd_checker (.*);
